@@ hw/rtl/jdpc_pkg.sv @@
// Shared constants, command codes and control types for the joint deadband controller.
package jdpc_pkg;

    localparam int NUM_JOINTS = 3;
    localparam int JW         = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    localparam int CMD_W      = 3;
    localparam int JOINT_W    = 3;
    localparam int POS_W      = 16;
    localparam int SPD_W      = 8;
    localparam int DB_W       = 15;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [JW-1:0] LAST_IDX = JW'(NUM_JOINTS - 1);

    localparam logic [CMD_W-1:0] CMD_SET_GOAL    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ENABLE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISABLE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ENABLE_ALL  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DISABLE_ALL = 3'd5;
    localparam logic [CMD_W-1:0] CMD_TICK        = 3'd6;
    localparam logic [CMD_W-1:0] CMD_HOLD        = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_POS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;

    localparam logic [63:0]     MAX_POS_RST  = 64'h7FFF_7FFF_7FFF_7FFF;
    localparam logic [63:0]     MIN_POS_RST  = 64'h8000_8000_8000_8000;
    localparam logic [31:0]     MAX_SPD_RST  = 32'hFFFF_FFFF;
    localparam logic [31:0]     MIN_SPD_RST  = 32'h0000_0000;
    localparam logic [DB_W-1:0] DEADBAND_RST = 15'd1;

    // Controller to datapath
    typedef struct packed {
        logic          load;
        logic          issue;
        logic          last_res;
        logic [JW-1:0] sel;
    } jdpc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic single;
        logic out_free;
    } jdpc_sts_t;

endpackage

@@ hw/rtl/joint_deadband_position_controller_top.sv @@
// Top level of the multi-joint bang-bang position controller with deadband.
//
// Channel   Dir  Signals                          Content
// s_axis    in   tvalid tready tdata tuser        request transaction
// m_axis    out  tvalid tready tdata tlast        one result per joint touched
// cfg       in   cfg_we cfg_index cfg_data        limit and deadband registers
//
// A request is accepted, then gives one result per cycle unless the output
// stalls: one for set goal, sample, enable and disable, NUM_JOINTS for the
// sweep commands (tick, hold, enable all, disable all), via the joint counter.
// Reset: all joint goals and positions 0, reached set, drives disabled.
// A stalled output holds the sweep; the next request is accepted while the
// last result still waits in the output register.
module joint_deadband_position_controller_top
    import jdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // joint[2:0], position[18:3], speed[26:19], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[2:0], zero fill
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_joint[2:0], direction[3], drive_speed[11:4], drive_valid[12],
    // reached[13], rejected[14], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    jdpc_cmd_t cmd;
    jdpc_sts_t sts;

    jdpc_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    jdpc_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

@@ hw/rtl/jdpc_ctrl.sv @@
// Sequencer: accepts one transaction, then steps the joint counter one result per cycle unless stalled.
module jdpc_ctrl
    import jdpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  jdpc_sts_t sts,
    output jdpc_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [JW-1:0] cnt_reg;
    logic [JW-1:0] cnt_next;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.load     = s_axis_tvalid && s_axis_tready;
        cmd.issue    = (state_reg == ST_RUN) && sts.out_free;
        cmd.last_res = sts.single || (cnt_reg == LAST_IDX);
        cmd.sel      = cnt_reg;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.issue)
                begin
                    if (cmd.last_res)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + JW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_IDX)
        else $error("joint counter out of range");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue && cmd.last_res |=> state_reg == ST_IDLE && cnt_reg == '0)
        else $error("sequencer did not return to idle after last result");

    a_no_accept_while_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_RUN && cnt_reg == '0)
        else $error("accepted transaction did not start a sweep at joint 0");
`endif

endmodule

@@ hw/rtl/jdpc_dp.sv @@
// Datapath: configuration registers, per-joint state, result logic and output register.
module jdpc_dp
    import jdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  jdpc_cmd_t             cmd,
    output jdpc_sts_t             sts
);

    // Configuration
    logic [63:0]     max_pos_reg;
    logic [63:0]     min_pos_reg;
    logic [31:0]     max_spd_reg;
    logic [31:0]     min_spd_reg;
    logic [DB_W-1:0] db_reg;

    // Per-joint state
    logic signed [POS_W-1:0] goal_pos_reg [NUM_JOINTS];
    logic signed [POS_W-1:0] goal_pos_next [NUM_JOINTS];
    logic [SPD_W-1:0]        goal_spd_reg [NUM_JOINTS];
    logic [SPD_W-1:0]        goal_spd_next [NUM_JOINTS];
    logic signed [POS_W-1:0] act_pos_reg [NUM_JOINTS];
    logic signed [POS_W-1:0] act_pos_next [NUM_JOINTS];
    logic [NUM_JOINTS-1:0]   rch_reg;
    logic [NUM_JOINTS-1:0]   rch_next;
    logic [NUM_JOINTS-1:0]   en_reg;
    logic [NUM_JOINTS-1:0]   en_next;

    // Held transaction
    logic [CMD_W-1:0]        item_cmd_reg;
    logic [JOINT_W-1:0]      item_joint_reg;
    logic signed [POS_W-1:0] item_pos_reg;
    logic [SPD_W-1:0]        item_spd_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  out_last_reg;

    logic                    single;
    logic                    bad_joint;
    logic [JW-1:0]           k;
    logic [JOINT_W-1:0]      oj;
    logic signed [POS_W-1:0] goal_sel;
    logic signed [POS_W-1:0] act_sel;
    logic signed [POS_W-1:0] max_f;
    logic signed [POS_W-1:0] min_f;
    logic [SPD_W-1:0]        smax_f;
    logic [SPD_W-1:0]        smin_f;
    logic                    lim_bad;
    logic signed [POS_W:0]   delta;
    logic signed [POS_W:0]   eps;
    logic signed [POS_W:0]   neg_eps;
    logic                    r_dir;
    logic [SPD_W-1:0]        r_spd;
    logic                    r_valid;
    logic                    r_rch;
    logic                    r_rej;

    assign single    = (item_cmd_reg <= CMD_DISABLE);
    assign bad_joint = single && (item_joint_reg >= JOINT_W'(NUM_JOINTS));
    assign k         = single ? item_joint_reg[JW-1:0] : cmd.sel;
    assign oj        = single ? item_joint_reg : JOINT_W'(cmd.sel);

    assign goal_sel = goal_pos_reg[k];
    assign act_sel  = act_pos_reg[k];
    assign max_f    = $signed(max_pos_reg[POS_W*k +: POS_W]);
    assign min_f    = $signed(min_pos_reg[POS_W*k +: POS_W]);
    assign smax_f   = max_spd_reg[SPD_W*k +: SPD_W];
    assign smin_f   = min_spd_reg[SPD_W*k +: SPD_W];

    assign lim_bad = (item_pos_reg > max_f) || (item_pos_reg < min_f) ||
                     (item_spd_reg > smax_f) || (item_spd_reg < smin_f);

    // Exact error, one guard bit
    assign delta   = $signed({act_sel[POS_W-1], act_sel}) -
                     $signed({goal_sel[POS_W-1], goal_sel});
    assign eps     = $signed({2'b00, db_reg});
    assign neg_eps = -eps;

    always_comb
    begin
        goal_pos_next = goal_pos_reg;
        goal_spd_next = goal_spd_reg;
        act_pos_next  = act_pos_reg;
        rch_next      = rch_reg;
        en_next       = en_reg;
        r_dir         = 1'b0;
        r_spd         = '0;
        r_valid       = 1'b0;
        r_rej         = 1'b0;
        if (cmd.issue && !bad_joint)
        begin
            case (item_cmd_reg) inside
                CMD_SET_GOAL:
                begin
                    if (lim_bad)
                    begin
                        r_rej = 1'b1;
                    end
                    else if (goal_sel != item_pos_reg)
                    begin
                        goal_pos_next[k] = item_pos_reg;
                        goal_spd_next[k] = item_spd_reg;
                        rch_next[k]      = 1'b0;
                    end
                end
                CMD_SAMPLE:
                begin
                    act_pos_next[k] = item_pos_reg;
                end
                CMD_ENABLE, CMD_ENABLE_ALL:
                begin
                    en_next[k] = 1'b1;
                end
                CMD_DISABLE, CMD_DISABLE_ALL:
                begin
                    en_next[k] = 1'b0;
                end
                CMD_HOLD:
                begin
                    goal_pos_next[k] = act_sel;
                    rch_next[k]      = 1'b1;
                end
                CMD_TICK:
                begin
                    if (en_reg[k])
                    begin
                        r_valid = 1'b1;
                        if (delta >= eps)
                        begin
                            r_spd = goal_spd_reg[k];
                        end
                        else if (delta <= neg_eps)
                        begin
                            r_dir = 1'b1;
                            r_spd = goal_spd_reg[k];
                        end
                        else
                        begin
                            rch_next[k] = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (bad_joint)
        begin
            r_rej = 1'b1;
            r_rch = 1'b0;
        end
        else
        begin
            r_rch = rch_next[k];
        end
    end

    // Pack result: out_joint, direction, drive_speed, drive_valid, reached, rejected
    assign out_data_next = {1'b0, r_rej, r_rch, r_valid, r_spd, r_dir, oj};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign sts.single   = single;
    assign sts.out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pos_reg <= MAX_POS_RST;
            min_pos_reg <= MIN_POS_RST;
            max_spd_reg <= MAX_SPD_RST;
            min_spd_reg <= MIN_SPD_RST;
            db_reg      <= DEADBAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_POS:  max_pos_reg <= cfg_data;
                REG_MIN_POS:  min_pos_reg <= cfg_data;
                REG_MAX_SPD:  max_spd_reg <= cfg_data[31:0];
                REG_MIN_SPD:  min_spd_reg <= cfg_data[31:0];
                REG_DEADBAND: db_reg      <= cfg_data[DB_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                goal_pos_reg[i] <= '0;
                goal_spd_reg[i] <= '0;
                act_pos_reg[i]  <= '0;
            end
            rch_reg       <= '1;
            en_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            goal_pos_reg  <= goal_pos_next;
            goal_spd_reg  <= goal_spd_next;
            act_pos_reg   <= act_pos_next;
            rch_reg       <= rch_next;
            en_reg        <= en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_cmd_reg   <= s_axis_tuser[CMD_W-1:0];
            item_joint_reg <= s_axis_tdata[JOINT_W-1:0];
            item_pos_reg   <= $signed(s_axis_tdata[JOINT_W +: POS_W]);
            item_spd_reg   <= s_axis_tdata[JOINT_W+POS_W +: SPD_W];
        end
        if (cmd.issue)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= cmd.last_res;
        end
    end

`ifndef ASSERT_OFF
    a_issue_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (!out_valid_reg || m_axis_tready))
        else $error("result issued over an untaken result");

    a_issue_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> m_axis_tvalid && m_axis_tlast == $past(cmd.last_res))
        else $error("issued result not presented");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");
`endif

endmodule

@@ sim/joint_deadband_position_controller_top_tb.sv @@
// Self-checking testbench for the joint deadband position controller: directed table, then random.
module joint_deadband_position_controller_top_tb;
    import jdpc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIRECTED_ROWS = 26;
    localparam int SPLIT_ROW     = 16;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 48;

    typedef struct packed {
        logic [2:0] out_joint;
        logic       direction;
        logic [7:0] drive_speed;
        logic       drive_valid;
        logic       reached;
        logic       rejected;
        logic       last;
    } drive_res_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  jn;
        logic [15:0] pos;
        logic [7:0]  spd;
        logic        typed;
        drive_res_t  want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Register mirror
    logic [63:0] max_pos;
    logic [63:0] min_pos;
    logic [31:0] max_spd;
    logic [31:0] min_spd;
    logic [14:0] db_cfg;

    // Joint state mirror
    logic [15:0] goal_pos [NUM_JOINTS];
    logic [7:0]  goal_spd [NUM_JOINTS];
    logic [15:0] act_pos [NUM_JOINTS];
    logic        joint_reached [NUM_JOINTS];
    logic        joint_enabled [NUM_JOINTS];

    drive_res_t pending_drives [$];
    stim_row_t  plan [DIRECTED_ROWS];

    int idle_pct = 0;
    int stall_pct = 0;
    int fault_count = 0;

    joint_deadband_position_controller_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic drive_res_t mk_res(input logic [2:0] jn, input logic rch,
                                          input logic rej);
        drive_res_t r;
        r = '0;
        r.out_joint = jn;
        r.reached   = rch;
        r.rejected  = rej;
        r.last      = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [2:0] c, input logic [2:0] jn,
                                         input logic [15:0] p, input logic [7:0] s,
                                         input logic typed, input drive_res_t want);
        stim_row_t row;
        row.cmd   = c;
        row.jn    = jn;
        row.pos   = p;
        row.spd   = s;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic string fmt_res(input drive_res_t r);
        return $sformatf("j%0d dir%0d spd%0d val%0d rch%0d rej%0d last%0d", r.out_joint,
                         r.direction, r.drive_speed, r.drive_valid, r.reached,
                         r.rejected, r.last);
    endfunction

    // Compute the drive results of one request and update the joint mirror.
    function automatic void predict_drive(input logic [2:0] c, input logic [2:0] jn,
                                          input logic [15:0] p, input logic [7:0] s);
        drive_res_t r;
        int delta;
        int band;
        int i;
        band = int'(db_cfg);
        r = '0;
        if (c <= CMD_DISABLE) begin
            r.out_joint = jn;
            r.last = 1'b1;
            if (jn >= NUM_JOINTS) begin
                r.rejected = 1'b1;
            end else begin
                case (c)
                    CMD_SET_GOAL:
                    begin
                        if ($signed(p) > $signed(max_pos[16*jn +: 16]) ||
                            $signed(p) < $signed(min_pos[16*jn +: 16]) ||
                            s > max_spd[8*jn +: 8] || s < min_spd[8*jn +: 8]) begin
                            r.rejected = 1'b1;
                        end else if (goal_pos[jn] != p) begin
                            goal_pos[jn] = p;
                            goal_spd[jn] = s;
                            joint_reached[jn] = 1'b0;
                        end
                    end
                    CMD_SAMPLE: act_pos[jn] = p;
                    CMD_ENABLE: joint_enabled[jn] = 1'b1;
                    default:    joint_enabled[jn] = 1'b0;
                endcase
                r.reached = joint_reached[jn];
            end
            pending_drives.push_back(r);
        end else begin
            for (i = 0; i < NUM_JOINTS; i++) begin
                r = '0;
                r.out_joint = 3'(i);
                case (c)
                    CMD_ENABLE_ALL:  joint_enabled[i] = 1'b1;
                    CMD_DISABLE_ALL: joint_enabled[i] = 1'b0;
                    CMD_HOLD:
                    begin
                        goal_pos[i] = act_pos[i];
                        joint_reached[i] = 1'b1;
                    end
                    default:
                    begin
                        if (joint_enabled[i]) begin
                            // exact error, no 16-bit wrap
                            delta = int'($signed(act_pos[i])) - int'($signed(goal_pos[i]));
                            r.drive_valid = 1'b1;
                            if (delta >= band) begin
                                r.drive_speed = goal_spd[i];
                            end else if (delta <= -band) begin
                                r.direction = 1'b1;
                                r.drive_speed = goal_spd[i];
                            end else begin
                                joint_reached[i] = 1'b1;
                            end
                        end
                    end
                endcase
                r.reached = joint_reached[i];
                r.last = (i == NUM_JOINTS - 1);
                pending_drives.push_back(r);
            end
        end
    endfunction

    task automatic send_item(input logic [2:0] c, input logic [2:0] jn,
                             input logic [15:0] p, input logic [7:0] s,
                             input logic typed, input drive_res_t want);
        int depth;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, s, p, jn};
        s_axis_tuser  <= {5'd0, c};
        do
            @(posedge clk);
        while (!s_axis_tready);
        depth = pending_drives.size();
        predict_drive(c, jn, p, s);
        if (typed) begin
            // keep the mirror updated, but check against the hand-written value
            while (pending_drives.size() > depth)
                void'(pending_drives.pop_back());
            pending_drives.push_back(want);
        end
    endtask

    task automatic send_random();
        logic [2:0] c;
        logic [2:0] jn;
        int p;
        int s;
        int r;
        int jj;
        r = $urandom_range(99);
        if (r < 24)      c = CMD_SET_GOAL;
        else if (r < 46) c = CMD_SAMPLE;
        else if (r < 54) c = CMD_ENABLE;
        else if (r < 60) c = CMD_DISABLE;
        else if (r < 68) c = CMD_ENABLE_ALL;
        else if (r < 72) c = CMD_DISABLE_ALL;
        else if (r < 94) c = CMD_TICK;
        else             c = CMD_HOLD;
        jn = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 3)) : 3'($urandom_range(2));
        jj = (jn < NUM_JOINTS) ? int'(jn) : 0;
        case ($urandom_range(4))
            0: p = int'($urandom_range(65535));
            1: p = int'($signed(max_pos[16*jj +: 16])) + int'($urandom_range(2)) - 1;
            2: p = int'($signed(min_pos[16*jj +: 16])) + int'($urandom_range(2)) - 1;
            3: p = int'($signed(goal_pos[jj]));
            default:
            begin
                // land just inside, on, or just outside the deadband edge
                p = int'(db_cfg) + int'($urandom_range(2)) - 1;
                if ($urandom_range(1) == 0)
                    p = -p;
                p = p + int'($signed(goal_pos[jj]));
            end
        endcase
        case ($urandom_range(2))
            0: s = int'($urandom_range(255));
            1: s = int'(max_spd[8*jj +: 8]) + int'($urandom_range(2)) - 1;
            default: s = int'(min_spd[8*jj +: 8]) + int'($urandom_range(2)) - 1;
        endcase
        send_item(c, jn, 16'(p), 8'(s), 1'b0, '0);
    endtask

    task automatic wait_idle();
        int k;
        k = 0;
        while (pending_drives.size() > 0 && k < 20000) begin
            @(posedge clk);
            k++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic load_settings(input logic [63:0] mp, input logic [63:0] np,
                                 input logic [31:0] ms, input logic [31:0] ns,
                                 input logic [14:0] dbv);
        logic [63:0]          vals [5];
        logic [CFG_IDX_W-1:0] ids [5];
        int i;
        vals[0] = mp;
        vals[1] = np;
        vals[2] = {32'd0, ms};
        vals[3] = {32'd0, ns};
        vals[4] = {49'd0, dbv};
        ids[0] = REG_MAX_POS;
        ids[1] = REG_MIN_POS;
        ids[2] = REG_MAX_SPD;
        ids[3] = REG_MIN_SPD;
        ids[4] = REG_DEADBAND;
        for (i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= ids[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            case (ids[i])
                REG_MAX_POS: max_pos = vals[i];
                REG_MIN_POS: min_pos = vals[i];
                REG_MAX_SPD: max_spd = vals[i][31:0];
                REG_MIN_SPD: min_spd = vals[i][31:0];
                default:     db_cfg  = vals[i][14:0];
            endcase
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        drive_res_t got;
        drive_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.out_joint   = m_axis_tdata[2:0];
            got.direction   = m_axis_tdata[3];
            got.drive_speed = m_axis_tdata[11:4];
            got.drive_valid = m_axis_tdata[12];
            got.reached     = m_axis_tdata[13];
            got.rejected    = m_axis_tdata[14];
            got.last        = m_axis_tlast;
            if (pending_drives.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: %s", fmt_res(got));
            end else begin
                want = pending_drives.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: expected %s, got %s", fmt_res(want),
                                 fmt_res(got));
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [63:0] mp;
        logic [63:0] np;
        logic [31:0] ms;
        logic [31:0] ns;
        logic [14:0] dbv;
        int k;
        int n;
        int j;
        int lo;
        int hi;
        int a;
        int b;

        max_pos = MAX_POS_RST;
        min_pos = MIN_POS_RST;
        max_spd = MAX_SPD_RST;
        min_spd = MIN_SPD_RST;
        db_cfg  = DEADBAND_RST;
        for (j = 0; j < NUM_JOINTS; j++) begin
            goal_pos[j] = '0;
            goal_spd[j] = '0;
            act_pos[j] = '0;
            joint_reached[j] = 1'b1;
            joint_enabled[j] = 1'b0;
        end

        // reset limits, full range
        plan[0]  = mk_row(CMD_SAMPLE, 3'd0, 16'd0, 8'd0, 1'b1, mk_res(3'd0, 1'b1, 1'b0));
        plan[1]  = mk_row(CMD_SET_GOAL, 3'd3, 16'd5, 8'd5, 1'b1, mk_res(3'd3, 1'b0, 1'b1));
        plan[2]  = mk_row(CMD_SAMPLE, 3'd7, 16'hFFFF, 8'hFF, 1'b1,
                          mk_res(3'd7, 1'b0, 1'b1));
        plan[3]  = mk_row(CMD_ENABLE, 3'd5, 16'd0, 8'd0, 1'b1, mk_res(3'd5, 1'b0, 1'b1));
        plan[4]  = mk_row(CMD_DISABLE, 3'd4, 16'd0, 8'd0, 1'b1, mk_res(3'd4, 1'b0, 1'b1));
        plan[5]  = mk_row(CMD_TICK, 3'd0, 16'd0, 8'd0, 1'b0, '0);
        plan[6]  = mk_row(CMD_SET_GOAL, 3'd0, 16'h7FFF, 8'hFF, 1'b0, '0);
        plan[7]  = mk_row(CMD_SET_GOAL, 3'd1, 16'h8000, 8'h00, 1'b0, '0);
        plan[8]  = mk_row(CMD_SET_GOAL, 3'd2, 16'd100, 8'd17, 1'b0, '0);
        plan[9]  = mk_row(CMD_SET_GOAL, 3'd2, 16'd100, 8'd99, 1'b0, '0);
        plan[10] = mk_row(CMD_ENABLE_ALL, 3'd7, 16'd0, 8'd0, 1'b0, '0);
        plan[11] = mk_row(CMD_SAMPLE, 3'd0, 16'h7FFF, 8'd0, 1'b0, '0);
        plan[12] = mk_row(CMD_SAMPLE, 3'd1, 16'h7FFF, 8'd0, 1'b0, '0);
        plan[13] = mk_row(CMD_SAMPLE, 3'd2, 16'h8000, 8'd0, 1'b0, '0);
        plan[14] = mk_row(CMD_TICK, 3'd0, 16'd0, 8'd0, 1'b0, '0);
        plan[15] = mk_row(CMD_HOLD, 3'd0, 16'd0, 8'd0, 1'b0, '0);
        // narrow joint 0, crossed joint 1, zero deadband
        plan[16] = mk_row(CMD_SET_GOAL, 3'd0, 16'd101, 8'd20, 1'b0, '0);
        plan[17] = mk_row(CMD_SET_GOAL, 3'd0, 16'hFF9B, 8'd20, 1'b0, '0);
        plan[18] = mk_row(CMD_SET_GOAL, 3'd0, 16'd50, 8'd51, 1'b0, '0);
        plan[19] = mk_row(CMD_SET_GOAL, 3'd0, 16'd50, 8'd9, 1'b0, '0);
        plan[20] = mk_row(CMD_SET_GOAL, 3'd0, 16'd100, 8'd50, 1'b0, '0);
        plan[21] = mk_row(CMD_SET_GOAL, 3'd0, 16'hFF9C, 8'd10, 1'b0, '0);
        plan[22] = mk_row(CMD_SET_GOAL, 3'd1, 16'd0, 8'd0, 1'b0, '0);
        plan[23] = mk_row(CMD_SAMPLE, 3'd0, 16'hFF9C, 8'd0, 1'b0, '0);
        plan[24] = mk_row(CMD_DISABLE_ALL, 3'd0, 16'd0, 8'd0, 1'b0, '0);
        plan[25] = mk_row(CMD_ENABLE_ALL, 3'd0, 16'd0, 8'd0, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            if (n == SPLIT_ROW) begin
                s_axis_tvalid <= 1'b0;
                wait_idle();
                load_settings({16'h7FFF, 16'h7FFF, 16'h8000, 16'd100},
                              {16'h8000, 16'h8000, 16'h7FFF, 16'hFF9C},
                              {8'hFF, 8'hFF, 8'hFF, 8'd50},
                              {8'h00, 8'h00, 8'h00, 8'd10}, 15'd0);
            end
            send_item(plan[n].cmd, plan[n].jn, plan[n].pos, plan[n].spd, plan[n].typed,
                      plan[n].want);
        end
        // zero deadband: an error of exactly zero still drives
        send_item(CMD_TICK, 3'd0, 16'd0, 8'd0, 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        for (k = 0; k < RAND_PHASES; k++) begin
            wait_idle();
            case (k % 5)
                0:
                begin
                    mp = MAX_POS_RST;
                    np = MIN_POS_RST;
                    ms = MAX_SPD_RST;
                    ns = MIN_SPD_RST;
                    dbv = 15'h7FFF;
                end
                1:
                begin
                    for (j = 0; j < 4; j++) begin
                        lo = int'($signed(16'($urandom)));
                        hi = lo + int'($urandom_range(4000));
                        if (hi > 32767)
                            hi = 32767;
                        mp[16*j +: 16] = 16'(hi);
                        np[16*j +: 16] = 16'(lo);
                        a = int'($urandom_range(255));
                        b = int'($urandom_range(255, a));
                        ms[8*j +: 8] = 8'(b);
                        ns[8*j +: 8] = 8'(a);
                    end
                    dbv = 15'($urandom_range(300, 1));
                end
                2:
                begin
                    // raw random limits, many of them crossed
                    mp = {$urandom, $urandom};
                    np = {$urandom, $urandom};
                    ms = $urandom;
                    ns = $urandom;
                    dbv = 15'($urandom_range(32767, 1));
                end
                3:
                begin
                    mp = {4{16'h8000}};
                    np = {4{16'h8000}};
                    ms = '0;
                    ns = '0;
                    dbv = 15'd0;
                end
                default:
                begin
                    mp = {4{16'h7FFF}};
                    np = {4{16'h7FFF}};
                    ms = '1;
                    ns = '1;
                    dbv = 15'd1;
                end
            endcase
            load_settings(mp, np, ms, ns, dbv);
            case (k % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 48;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 48;
                end
                default:
                begin
                    idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random();
            s_axis_tvalid <= 1'b0;
        end

        wait_idle();
        fault_count += pending_drives.size();
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/jdpc_pkg.sv
hw/rtl/jdpc_ctrl.sv
hw/rtl/jdpc_dp.sv
hw/rtl/joint_deadband_position_controller_top.sv
sim/joint_deadband_position_controller_top_tb.sv
